[design/mamacd_pkg.sv]
// ----------------------------------------------------------------------------
// mamacd_pkg
// Shared types and constants for the moving average / MACD stream block.
// ----------------------------------------------------------------------------
package mamacd_pkg;

    localparam int DEF_MAX_WINDOW = 128;
    localparam int DEF_PRICE_BITS = 32;
    localparam int NUM_WINDOWS    = 6;
    localparam int WIN_BITS       = 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int SUM_BITS       = 64;
    localparam int Q_FRAC         = 16;
    // quotient bits resolved per divider cycle
    localparam int DIV_BITS       = 8;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET [NUM_WINDOWS] =
        '{8'd5, 8'd10, 8'd20, 8'd30, 8'd60, 8'd120};

    localparam int FAST_DIV = 13;
    localparam int SLOW_DIV = 27;
    localparam int SIG_DIV  = 10;

    typedef logic [3:0] op_t;
    localparam op_t OP_MEAN_FIRST = 4'd0;
    localparam op_t OP_MEAN_LAST  = 4'd5;
    localparam op_t OP_FAST       = 4'd6;
    localparam op_t OP_SLOW       = 4'd7;
    localparam op_t OP_SIG        = 4'd8;

    typedef struct packed {
        logic capture;
        logic rd;
        logic sum;
        logic prep;
        logic step;
        logic store;
        logic fin;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic first;
        logic out_busy;
    } status_t;

endpackage

[design/mamacd_ctrl.sv]
// ----------------------------------------------------------------------------
// mamacd_ctrl
// Sequencer: walks the six window means and the three MACD divisions.
// ----------------------------------------------------------------------------
module mamacd_ctrl #(
    parameter int PRICE_BITS = mamacd_pkg::DEF_PRICE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mamacd_pkg::status_t status,
    output mamacd_pkg::cmd_t    cmd
);
    import mamacd_pkg::*;

    localparam int EMA_W = PRICE_BITS + Q_FRAC;
    localparam int QS    = (PRICE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int ES    = (EMA_W + 5 + DIV_BITS - 1) / DIV_BITS;
    localparam int CW    = $clog2(ES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_PREP  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_STORE = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [CW-1:0]   step_reg, step_next;
    logic [CW-1:0]   steps_last;
    state_t          adv_state;
    op_t             adv_op;

    assign steps_last = (op_reg <= OP_MEAN_LAST) ? CW'(QS - 1) : CW'(ES - 1);

    // where to go once the current operation is finished
    always_comb begin
        adv_op = op_reg + 4'd1;
        if (op_reg == OP_SIG || (op_reg == OP_MEAN_LAST && status.first)) begin
            adv_state = S_FIN;
            adv_op    = op_reg;
        end else if (adv_op <= OP_MEAN_LAST) begin
            adv_state = S_RD;
        end else begin
            adv_state = S_PREP;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    op_next     = OP_MEAN_FIRST;
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep  = 1'b1;
                step_next = '0;
                if (status.need_div) begin
                    state_next = S_DIV;
                end else begin
                    state_next = adv_state;
                    op_next    = adv_op;
                end
            end
            S_DIV: begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == steps_last) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = adv_state;
                op_next    = adv_op;
            end
            S_FIN: begin
                if (!status.out_busy) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_MEAN_FIRST;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> step_reg <= steps_last)
        else $error("divider step count overran");
    a_store_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_STORE |-> $past(state_reg) == S_DIV)
        else $error("store without division");
    a_fin_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        op_reg <= OP_SIG)
        else $error("operation index out of range");
`endif

endmodule

[design/mamacd_dp.sv]
// ----------------------------------------------------------------------------
// mamacd_dp
// Datapath: price ring, window sums, EMA/signal state, shared radix divider
// and the output register.
// ----------------------------------------------------------------------------
module mamacd_dp #(
    parameter int MAX_WINDOW = mamacd_pkg::DEF_MAX_WINDOW,
    parameter int PRICE_BITS = mamacd_pkg::DEF_PRICE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  mamacd_pkg::cmd_t                       cmd,
    output mamacd_pkg::status_t                    status,
    input  logic                                   cfg_wr_en,
    input  logic [mamacd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mamacd_pkg::WIN_BITS-1:0]        cfg_data,
    input  logic                                   s_start_of_series,
    input  logic [PRICE_BITS-1:0]                  s_close_price,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [PRICE_BITS:0]             mean_out [mamacd_pkg::NUM_WINDOWS],
    output logic [PRICE_BITS+15:0]                 m_fast_ema,
    output logic [PRICE_BITS+15:0]                 m_slow_ema,
    output logic signed [PRICE_BITS+16:0]          m_macd_diff,
    output logic signed [PRICE_BITS+16:0]          m_macd_signal,
    output logic signed [PRICE_BITS+18:0]          m_macd_bar
);
    import mamacd_pkg::*;

    localparam int E     = PRICE_BITS + Q_FRAC;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int DV    = (NW > 5) ? NW : 5;
    localparam int QS    = (PRICE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int QW    = QS * DIV_BITS;
    localparam int ES    = (E + 5 + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W = ES * DIV_BITS;
    localparam int SW    = SUM_BITS;

    logic [WIN_BITS-1:0]   win_reg [NUM_WINDOWS];
    logic [PRICE_BITS-1:0] close_reg;
    logic [SW-1:0]         sums_reg [NUM_WINDOWS];
    logic [NW-1:0]         items_reg;
    logic [AW-1:0]         ptr_reg;
    logic [E-1:0]          fast_reg, slow_reg;
    logic signed [E:0]     sig_reg;
    logic signed [PRICE_BITS:0] mean_reg [NUM_WINDOWS];
    logic [PRICE_BITS-1:0] mem [MAX_WINDOW];
    logic [PRICE_BITS-1:0] rd_data_reg;
    logic [DV-1:0]         rem_reg, rem_next;
    logic [DV-1:0]         dvs_reg;
    logic [DIV_W-1:0]      dvd_reg, dvd_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic                  neg_reg;
    logic                  m_valid_reg;

    logic [2:0]            widx;
    logic [15:0]           w16;
    logic [NW-1:0]         n_cur;
    logic [AW+1:0]         back_sum;
    logic [AW-1:0]         rd_addr;
    logic [SW-1:0]         sum_cur;
    logic                  full, sat;
    logic signed [E:0]     diff_w;
    logic signed [E+4:0]   sig_num;
    logic [E+4:0]          sig_mag;
    logic [E+4:0]          fast_num, slow_num;
    logic signed [E+2:0]   bar_w;
    logic signed [E:0]     dea_w;

    assign widx    = (cmd.op <= OP_MEAN_LAST) ? cmd.op[2:0] : 3'd0;
    assign w16     = {8'd0, win_reg[widx]};
    always_comb begin
        if (w16 == 16'd0) begin
            n_cur = NW'(1);
        end else if (w16 > 16'(MAX_WINDOW)) begin
            n_cur = NW'(MAX_WINDOW);
        end else begin
            n_cur = NW'(w16);
        end
    end

    // slot written n items ago, modulo the ring length
    assign back_sum = (AW+2)'(ptr_reg) + (AW+2)'(MAX_WINDOW) - (AW+2)'(n_cur);
    assign rd_addr  = (back_sum >= (AW+2)'(MAX_WINDOW)) ?
                      AW'(back_sum - (AW+2)'(MAX_WINDOW)) : AW'(back_sum);

    assign sum_cur = sums_reg[widx];
    assign full    = ((NW+1)'(items_reg) + (NW+1)'(1)) >= (NW+1)'(n_cur);
    assign sat     = sum_cur >= (SW'(n_cur) << PRICE_BITS);

    assign diff_w   = $signed({1'b0, fast_reg}) - $signed({1'b0, slow_reg});
    assign sig_num  = ($signed({{4{sig_reg[E]}}, sig_reg}) <<< 3)
                    + ($signed({{4{diff_w[E]}}, diff_w}) <<< 1);
    assign sig_mag  = sig_num[E+4] ? (E+5)'(-sig_num) : (E+5)'(sig_num);
    // 2*q + 11*prev and 2*q + 25*prev by shifts and adds
    assign fast_num = {4'd0, close_reg, 17'd0}
                    + ((E+5)'(fast_reg) << 3) + ((E+5)'(fast_reg) << 1)
                    + (E+5)'(fast_reg);
    assign slow_num = {4'd0, close_reg, 17'd0}
                    + ((E+5)'(slow_reg) << 4) + ((E+5)'(slow_reg) << 3)
                    + (E+5)'(slow_reg);
    assign dea_w    = neg_reg ? -$signed({1'b0, quo_reg[E-1:0]})
                              :  $signed({1'b0, quo_reg[E-1:0]});
    assign bar_w    = ($signed({{2{diff_w[E]}}, diff_w})
                    -  $signed({{2{sig_reg[E]}}, sig_reg})) <<< 1;

    assign status.need_div = (cmd.op <= OP_MEAN_LAST) ? (full && !sat) : 1'b1;
    assign status.first    = (items_reg == '0);
    assign status.out_busy = m_valid_reg && !m_ready;

    // one radix-256 restoring step
    always_comb begin
        logic [DV:0]           r;
        logic [DIV_BITS-1:0]   qb;
        r  = {1'b0, rem_reg};
        qb = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            r = {r[DV-1:0], dvd_reg[DIV_W-1-i]};
            if (r >= {1'b0, dvs_reg}) begin
                r = r - {1'b0, dvs_reg};
                qb[DIV_BITS-1-i] = 1'b1;
            end
        end
        rem_next = r[DV-1:0];
        dvd_next = dvd_reg << DIV_BITS;
        quo_next = {quo_reg[DIV_W-DIV_BITS-1:0], qb};
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.fin) begin
            mem[ptr_reg] <= close_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            close_reg <= s_close_price;
        end
        if (cmd.prep) begin
            quo_reg <= '0;
            neg_reg <= 1'b0;
            case (cmd.op)
                OP_FAST: begin
                    dvd_reg <= DIV_W'(fast_num);
                    rem_reg <= '0;
                    dvs_reg <= DV'(FAST_DIV);
                end
                OP_SLOW: begin
                    dvd_reg <= DIV_W'(slow_num);
                    rem_reg <= '0;
                    dvs_reg <= DV'(SLOW_DIV);
                end
                OP_SIG: begin
                    dvd_reg <= DIV_W'(sig_mag);
                    rem_reg <= '0;
                    dvs_reg <= DV'(SIG_DIV);
                    neg_reg <= sig_num[E+4];
                end
                default: begin
                    dvd_reg <= {sum_cur[QW-1:0], {(DIV_W-QW){1'b0}}};
                    rem_reg <= DV'(sum_cur >> QW);
                    dvs_reg <= DV'(n_cur);
                    if (!full) begin
                        mean_reg[widx] <= '1;
                    end else if (sat) begin
                        mean_reg[widx] <= {1'b0, {PRICE_BITS{1'b1}}};
                    end
                end
            endcase
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
        if (cmd.store && cmd.op <= OP_MEAN_LAST) begin
            mean_reg[widx] <= {1'b0, quo_reg[PRICE_BITS-1:0]};
        end
        if (cmd.fin) begin
            for (int k = 0; k < NUM_WINDOWS; k++) begin
                mean_out[k] <= mean_reg[k];
            end
            m_fast_ema    <= fast_reg;
            m_slow_ema    <= slow_reg;
            m_macd_diff   <= diff_w;
            m_macd_signal <= sig_reg;
            m_macd_bar    <= bar_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_WINDOWS; k++) begin
                win_reg[k]  <= WINDOW_RESET[k];
                sums_reg[k] <= '0;
            end
            items_reg   <= '0;
            ptr_reg     <= '0;
            fast_reg    <= '0;
            slow_reg    <= '0;
            sig_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index < CFG_IDX_BITS'(NUM_WINDOWS)) begin
                win_reg[cfg_index] <= cfg_data;
            end
            if (cmd.capture && s_start_of_series) begin
                for (int k = 0; k < NUM_WINDOWS; k++) begin
                    sums_reg[k] <= '0;
                end
                items_reg <= '0;
                fast_reg  <= '0;
                slow_reg  <= '0;
                sig_reg   <= '0;
            end
            if (cmd.sum) begin
                sums_reg[widx] <= sum_cur + SW'(close_reg)
                    - ((items_reg >= n_cur) ? SW'(rd_data_reg) : SW'(0));
            end
            if (cmd.store) begin
                case (cmd.op)
                    OP_FAST: fast_reg <= quo_reg[E-1:0];
                    OP_SLOW: slow_reg <= quo_reg[E-1:0];
                    OP_SIG:  sig_reg  <= dea_w;
                    default: ;
                endcase
            end
            if (cmd.fin) begin
                ptr_reg <= (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                if (items_reg < NW'(MAX_WINDOW)) begin
                    items_reg <= items_reg + 1'b1;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[design/moving_average_macd_stream.sv]
// Moving average and MACD stream: one closing price per request, one result per
// request with six truncated window means (-1 until the window has filled) and
// the Q16 MACD set. Requests are worked one at a time by a sequencer around a
// single shared divider that resolves 8 quotient bits a cycle. Each window mean
// steps through read, sum, prepare, divide and store, skipping the division
// while its window is still filling or the mean saturates; after the first item
// of a series the two EMAs and the signal line each add a prepare, divide and
// store. A finished result waits in an output register while the next request
// is taken; the next result is held back, and the input with it, for as long
// as that register is not drained. The user is to write window lengths through
// the cfg port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
// moving_average_macd_stream
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
module moving_average_macd_stream #(
    parameter int MAX_WINDOW = mamacd_pkg::DEF_MAX_WINDOW,
    parameter int PRICE_BITS = mamacd_pkg::DEF_PRICE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [mamacd_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mamacd_pkg::WIN_BITS-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_start_of_series,
    input  logic [PRICE_BITS-1:0]               s_close_price,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [PRICE_BITS:0]          m_mean_a,
    output logic signed [PRICE_BITS:0]          m_mean_b,
    output logic signed [PRICE_BITS:0]          m_mean_c,
    output logic signed [PRICE_BITS:0]          m_mean_d,
    output logic signed [PRICE_BITS:0]          m_mean_e,
    output logic signed [PRICE_BITS:0]          m_mean_f,
    output logic [PRICE_BITS+15:0]              m_fast_ema,
    output logic [PRICE_BITS+15:0]              m_slow_ema,
    output logic signed [PRICE_BITS+16:0]       m_macd_diff,
    output logic signed [PRICE_BITS+16:0]       m_macd_signal,
    output logic signed [PRICE_BITS+18:0]       m_macd_bar
);
    import mamacd_pkg::*;

    cmd_t                       cmd;
    status_t                    status;
    logic signed [PRICE_BITS:0] mean_out [NUM_WINDOWS];

    mamacd_ctrl #(
        .PRICE_BITS (PRICE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mamacd_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_start_of_series (s_start_of_series),
        .s_close_price     (s_close_price),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .mean_out          (mean_out),
        .m_fast_ema        (m_fast_ema),
        .m_slow_ema        (m_slow_ema),
        .m_macd_diff       (m_macd_diff),
        .m_macd_signal     (m_macd_signal),
        .m_macd_bar        (m_macd_bar)
    );

    assign m_mean_a = mean_out[0];
    assign m_mean_b = mean_out[1];
    assign m_mean_c = mean_out[2];
    assign m_mean_d = mean_out[3];
    assign m_mean_e = mean_out[4];
    assign m_mean_f = mean_out[5];

endmodule

[test/moving_average_macd_stream_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_macd_stream_test
// Drives closing prices through the block with random bursts and output
// stalls, predicts the six window means and the MACD set per request and
// compares every result field by field, across several window settings.
// ----------------------------------------------------------------------------

class macd_scoreboard;

    typedef struct packed {
        logic signed [32:0] mean_a;
        logic signed [32:0] mean_b;
        logic signed [32:0] mean_c;
        logic signed [32:0] mean_d;
        logic signed [32:0] mean_e;
        logic signed [32:0] mean_f;
        logic [47:0]        fast_ema;
        logic [47:0]        slow_ema;
        logic signed [48:0] macd_diff;
        logic signed [48:0] macd_signal;
        logic signed [50:0] macd_bar;
    } macd_result_t;

    logic [7:0]  win_len [6];
    logic [31:0] price_ring [128];
    logic [63:0] win_sum [6];
    int          seen;
    int          ring_ptr;
    logic [63:0] fast_q;
    logic [63:0] slow_q;
    longint      signal_q;
    macd_result_t pending_results [$];
    int          errors;

    function new();
        for (int i = 0; i < 6; i++) begin
            win_len[i] = mamacd_pkg::WINDOW_RESET[i];
            win_sum[i] = '0;
        end
        seen = 0;
        ring_ptr = 0;
        fast_q = '0;
        slow_q = '0;
        signal_q = 0;
        errors = 0;
    endfunction

    function void set_window(int idx, logic [7:0] val);
        if (idx < 6) begin
            win_len[idx] = val;
        end
    endfunction

    function void note_request(logic start, logic [31:0] close);
        macd_result_t r;
        int n;
        logic [63:0] sum;
        logic [63:0] mean;
        longint diff;
        longint dea;
        longint bar;
        logic signed [32:0] means [6];
        if (start) begin
            for (int i = 0; i < 6; i++) begin
                win_sum[i] = '0;
            end
            seen = 0;
            fast_q = '0;
            slow_q = '0;
            signal_q = 0;
        end
        for (int w = 0; w < 6; w++) begin
            n = win_len[w];
            if (n == 0) begin
                n = 1;
            end
            if (n > 128) begin
                n = 128;
            end
            sum = win_sum[w];
            if (seen >= n) begin
                sum = sum - price_ring[(ring_ptr + 128 - n) % 128];
            end
            sum = sum + close;
            win_sum[w] = sum;
            if (seen + 1 >= n) begin
                mean = sum / n;
                if (mean > 64'hFFFF_FFFF) begin
                    mean = 64'hFFFF_FFFF;
                end
                means[w] = mean[32:0];
            end else begin
                means[w] = '1;
            end
        end
        if (seen == 0) begin
            fast_q = '0;
            slow_q = '0;
            signal_q = 0;
            diff = 0;
            bar = 0;
        end else begin
            fast_q = (2 * ({32'd0, close} << 16) + 11 * fast_q) / 13;
            slow_q = (2 * ({32'd0, close} << 16) + 25 * slow_q) / 27;
            diff = longint'(fast_q) - longint'(slow_q);
            dea = (8 * signal_q + 2 * diff) / 10;
            signal_q = dea;
            bar = 2 * (diff - dea);
        end
        r.mean_a = means[0];
        r.mean_b = means[1];
        r.mean_c = means[2];
        r.mean_d = means[3];
        r.mean_e = means[4];
        r.mean_f = means[5];
        r.fast_ema = fast_q[47:0];
        r.slow_ema = slow_q[47:0];
        r.macd_diff = diff[48:0];
        r.macd_signal = signal_q[48:0];
        r.macd_bar = bar[50:0];
        pending_results.push_back(r);
        price_ring[ring_ptr] = close;
        ring_ptr = (ring_ptr + 1) % 128;
        if (seen < 128) begin
            seen++;
        end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_result(macd_result_t act);
        macd_result_t e;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, act);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        compare_field("mean_a", 64'(e.mean_a), 64'(act.mean_a));
        compare_field("mean_b", 64'(e.mean_b), 64'(act.mean_b));
        compare_field("mean_c", 64'(e.mean_c), 64'(act.mean_c));
        compare_field("mean_d", 64'(e.mean_d), 64'(act.mean_d));
        compare_field("mean_e", 64'(e.mean_e), 64'(act.mean_e));
        compare_field("mean_f", 64'(e.mean_f), 64'(act.mean_f));
        compare_field("fast_ema", 64'(e.fast_ema), 64'(act.fast_ema));
        compare_field("slow_ema", 64'(e.slow_ema), 64'(act.slow_ema));
        compare_field("macd_diff", 64'(e.macd_diff), 64'(act.macd_diff));
        compare_field("macd_signal", 64'(e.macd_signal), 64'(act.macd_signal));
        compare_field("macd_bar", 64'(e.macd_bar), 64'(act.macd_bar));
    endfunction

endclass

module moving_average_macd_stream_test;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_start_of_series = 1'b0;
    logic [31:0] s_close_price = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [32:0] m_mean_a, m_mean_b, m_mean_c, m_mean_d, m_mean_e, m_mean_f;
    logic [47:0] m_fast_ema, m_slow_ema;
    logic signed [48:0] m_macd_diff, m_macd_signal;
    logic signed [50:0] m_macd_bar;

    macd_scoreboard price_board = new();
    int  cycle_count = 0;
    bit  stall_long = 1'b0;
    bit  burst_mode = 1'b1;

    always #5 aclk = ~aclk;

    moving_average_macd_stream i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_of_series(s_start_of_series), .s_close_price(s_close_price),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mean_a(m_mean_a), .m_mean_b(m_mean_b), .m_mean_c(m_mean_c),
        .m_mean_d(m_mean_d), .m_mean_e(m_mean_e), .m_mean_f(m_mean_f),
        .m_fast_ema(m_fast_ema), .m_slow_ema(m_slow_ema),
        .m_macd_diff(m_macd_diff), .m_macd_signal(m_macd_signal),
        .m_macd_bar(m_macd_bar)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("moving_average_macd_stream_test failed");
            $finish;
        end
    end

    // result check at each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            price_board.check_result({m_mean_a, m_mean_b, m_mean_c, m_mean_d, m_mean_e,
                m_mean_f, m_fast_ema, m_slow_ema, m_macd_diff, m_macd_signal, m_macd_bar});
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (stall_long && hold_left == 0) begin
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!burst_mode) begin
            m_ready <= 1'b1;
            hold_left <= stall_long ? hold_left : 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(1, 120);
            end
        end
    end

    task automatic send_price(logic start, logic [31:0] close);
        s_valid <= 1'b1;
        s_start_of_series <= start;
        s_close_price <= close;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        price_board.note_request(start, close);
    endtask

    task automatic pause_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (price_board.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_window(int idx, logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx[2:0];
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        price_board.set_window(idx, val);
    endtask

    task automatic set_all(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                           logic [7:0] d, logic [7:0] e, logic [7:0] f);
        write_window(0, a);
        write_window(1, b);
        write_window(2, c);
        write_window(3, d);
        write_window(4, e);
        write_window(5, f);
        // index past the six windows must be ignored
        write_window(6, 8'd77);
        write_window(7, 8'd3);
    endtask

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom();
            default: return 32'd100000 + $urandom_range(0, 50000);
        endcase
    endfunction

    task automatic run_random(int count, int restart_odds);
        int gap;
        for (int i = 0; i < count; i++) begin
            if (burst_mode && $urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 200);
                pause_sender(gap);
            end
            send_price($urandom_range(0, restart_odds) == 0, rand_price());
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: first item after reset, extremes, window of zero and above max
        set_all(8'd1, 8'd2, 8'd0, 8'd128, 8'd255, 8'd3);
        send_price(1'b0, 32'hFFFF_FFFF);
        send_price(1'b0, 32'hFFFF_FFFF);
        send_price(1'b0, 32'd0);
        send_price(1'b0, 32'hFFFF_FFFF);
        send_price(1'b0, 32'd0);
        send_price(1'b1, 32'd1);
        send_price(1'b0, 32'hAAAA_AAAA);
        send_price(1'b0, 32'h5555_5555);
        send_price(1'b0, 32'hFFFF_FFFF);
        send_price(1'b0, 32'd0);
        for (int i = 0; i < 10; i++) begin
            send_price(1'b0, 32'd200000 - i * 1000);
        end
        wait_drained();

        // reset defaults back, long sequences fill the big windows
        set_all(8'd5, 8'd10, 8'd20, 8'd30, 8'd60, 8'd120);
        run_random(350, 400);
        wait_drained();

        // change a window inside a running series, no restart
        write_window(1, 8'd3);
        write_window(4, 8'd128);
        run_random(150, 1000);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        stall_long = 1'b1;
        fork
            run_random(20, 50);
            begin
                repeat (10) @(posedge aclk);
                stall_long = 1'b0;
            end
        join
        wait_drained();

        set_all(8'd1, 8'd128, 8'd7, 8'd2, 8'd64, 8'd100);
        run_random(300, 150);
        wait_drained();

        // no idling on either side
        burst_mode = 1'b0;
        set_all(8'd128, 8'd1, 8'd33, 8'd12, 8'd26, 8'd9);
        run_random(300, 200);
        wait_drained();
        burst_mode = 1'b1;

        set_all(8'd4, 8'd8, 8'd16, 8'd32, 8'd127, 8'd128);
        run_random(300, 300);
        wait_drained();

        if (price_board.errors == 0) begin
            $display("moving_average_macd_stream_test passed");
        end else begin
            $display("moving_average_macd_stream_test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/mamacd_pkg.sv
design/mamacd_ctrl.sv
design/mamacd_dp.sv
design/moving_average_macd_stream.sv
test/moving_average_macd_stream_test.sv
